### sv/sbsh_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Shared types, initial hash values, the round constant table and the
// SHA-256 bit functions used by the round logic.
// ----------------------------------------------------------------------------
package sbsh_pkg;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_UPDATE,
        S_EMIT
    } t_state;

    typedef logic [31:0] t_word;

    localparam int unsigned NUM_HASH_WORDS = 8;
    localparam int unsigned NUM_SCHED_WORDS = 16;
    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_FIELD_START = 6'd56;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [5:0] LAST_BYTE_SLOT = 6'd63;
    localparam logic [2:0] LAST_WORD_INDEX = 3'd7;

    // Initial hash value H0..H7.
    localparam t_word HASH_IV [NUM_HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Round constant for round idx.
    function automatic t_word round_k(input logic [5:0] idx);
        t_word k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic t_word ror32(input t_word v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // Upper-case sigma functions of the round.
    function automatic t_word big_sigma0(input t_word a);
        return ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word e);
        return ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25);
    endfunction

    // Lower-case sigma functions of the message schedule.
    function automatic t_word small_sigma0(input t_word x);
        return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
    endfunction

endpackage

### sv/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Collects message bytes into a 512-bit block, compresses each full block
// with one shared round unit, pads the message on its final beat and
// returns the digest as eight 32-bit words.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake                  Payload
//  -------  -------------------------  -------------------------------------
//  input    i_in_valid / o_in_ready    i_byte_present, i_data_byte,
//                                      i_end_of_message
//  output   o_out_valid / i_out_ready  o_digest_word, o_word_index,
//                                      o_last_word
//
// A byte beat is taken while idle; the beat that fills a block then runs
// the rounds on the single round unit and folds the result into the hash.
// A final beat adds padding bytes (up to 64, or up to 72 when the length
// field spills into a second block), compresses each padded block, then
// emits eight output beats. The input is not ready while padding, compressing
// or emitting. Reset is synchronous and clears the sequencer, the fill count,
// the length count and restores the initial hash value. Output stalls hold
// the current digest word.
module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_byte_present,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sbsh_pkg::*;

    // Sequencer and control registers.
    t_state      r_state, n_state;
    logic [5:0]  r_fill;
    logic [5:0]  r_rnd;
    logic [2:0]  r_widx;
    logic [60:0] r_msg_bytes;
    logic        r_fin;
    logic        r_mark_done;
    logic        r_wrap;
    logic        r_last_blk;

    // Datapath registers.
    t_word r_hash [NUM_HASH_WORDS];
    t_word r_wv   [NUM_HASH_WORDS];
    t_word r_w    [NUM_SCHED_WORDS];

    // Decoded controls.
    logic       w_in_acc;
    logic       w_out_acc;
    logic       w_push;
    logic       w_push_in;
    logic [7:0] w_push_byte;
    logic       w_len_phase;
    logic [7:0] w_len_byte;
    logic [63:0] w_len;
    logic       w_blk_full;

    // Round unit signals.
    t_word w_t1, w_t2, w_new_w;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    // Length field bytes, most significant first, selected by fill position.
    assign w_len       = {r_msg_bytes, 3'b000};
    assign w_len_byte  = w_len[{3'd7 - r_fill[2:0], 3'b000} +: 8];
    assign w_len_phase = r_mark_done && !r_wrap && (r_fill >= LEN_FIELD_START);

    // Byte source for the block window: input beats when idle, padding otherwise.
    always_comb begin
        w_push_in = (r_state == S_IDLE) && w_in_acc && i_byte_present;
        w_push    = w_push_in || (r_state == S_PAD);
        if (r_state == S_IDLE) begin
            w_push_byte = i_data_byte;
        end else if (!r_mark_done) begin
            w_push_byte = PAD_MARK;
        end else if (w_len_phase) begin
            w_push_byte = w_len_byte;
        end else begin
            w_push_byte = 8'h00;
        end
    end

    assign w_blk_full = w_push && (r_fill == LAST_BYTE_SLOT);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_byte_present && (r_fill == LAST_BYTE_SLOT)) begin
                        n_state = S_ROUND;
                    end else if (i_end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (r_fill == LAST_BYTE_SLOT) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                if (r_rnd == LAST_ROUND) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (r_last_blk) begin
                    n_state = S_EMIT;
                end else if (r_fin) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_out_ready && (r_widx == LAST_WORD_INDEX)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE:   o_in_ready  = 1'b1;
            S_EMIT:   o_out_valid = 1'b1;
            S_PAD, S_ROUND, S_UPDATE: begin
                o_in_ready  = 1'b0;
                o_out_valid = 1'b0;
            end
            default: begin
                o_in_ready  = 1'b0;
                o_out_valid = 1'b0;
            end
        endcase
    end

    assign o_digest_word = r_hash[0];
    assign o_word_index  = r_widx;
    assign o_last_word   = (r_widx == LAST_WORD_INDEX);

    // One SHA-256 round and one schedule word per cycle.
    always_comb begin
        w_t1 = r_wv[7] + big_sigma1(r_wv[4])
             + ((r_wv[4] & r_wv[5]) ^ (~r_wv[4] & r_wv[6]))
             + round_k(r_rnd) + r_w[0];
        w_t2 = big_sigma0(r_wv[0])
             + ((r_wv[0] & r_wv[1]) ^ (r_wv[0] & r_wv[2]) ^ (r_wv[1] & r_wv[2]));
        w_new_w = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_rnd       <= '0;
            r_widx      <= '0;
            r_msg_bytes <= '0;
            r_fin       <= 1'b0;
            r_mark_done <= 1'b0;
            r_wrap      <= 1'b0;
            r_last_blk  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_push) begin
                r_fill <= r_fill + 6'd1;
            end
            if (w_push_in) begin
                r_msg_bytes <= r_msg_bytes + 61'd1;
            end
            if ((r_state == S_IDLE) && w_in_acc && i_end_of_message) begin
                r_fin <= 1'b1;
            end
            // Padding marker, spill into a second block, and the final block.
            // A marker in the last slot fills its block, so the next block
            // carries the length field directly.
            if (r_state == S_PAD) begin
                if (!r_mark_done) begin
                    r_mark_done <= 1'b1;
                    r_wrap      <= (r_fill >= LEN_FIELD_START) &&
                                   (r_fill != LAST_BYTE_SLOT);
                end else if (w_blk_full) begin
                    r_wrap <= 1'b0;
                end
                if (w_blk_full && w_len_phase) begin
                    r_last_blk <= 1'b1;
                end
            end
            if (r_state == S_ROUND) begin
                r_rnd <= r_rnd + 6'd1;
            end
            // Digest words leave one per output beat, then the hasher starts over.
            if (w_out_acc) begin
                r_widx <= r_widx + 3'd1;
                if (r_widx == LAST_WORD_INDEX) begin
                    r_fill      <= '0;
                    r_msg_bytes <= '0;
                    r_fin       <= 1'b0;
                    r_mark_done <= 1'b0;
                    r_wrap      <= 1'b0;
                    r_last_blk  <= 1'b0;
                end
            end
        end
    end

    // Hash words: reset value, fold after compression, rotate while emitting.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_HASH_WORDS; i++) begin
                r_hash[i] <= HASH_IV[i];
            end
        end else if (r_state == S_UPDATE) begin
            for (int i = 0; i < NUM_HASH_WORDS; i++) begin
                r_hash[i] <= r_hash[i] + r_wv[i];
            end
        end else if (w_out_acc) begin
            if (r_widx == LAST_WORD_INDEX) begin
                for (int i = 0; i < NUM_HASH_WORDS; i++) begin
                    r_hash[i] <= HASH_IV[i];
                end
            end else begin
                for (int i = 0; i < NUM_HASH_WORDS - 1; i++) begin
                    r_hash[i] <= r_hash[i + 1];
                end
                r_hash[NUM_HASH_WORDS - 1] <= r_hash[0];
            end
        end
    end

    // Working variables: loaded from the hash on the byte that fills a block.
    always_ff @(posedge i_clk) begin
        if (w_blk_full) begin
            for (int i = 0; i < NUM_HASH_WORDS; i++) begin
                r_wv[i] <= r_hash[i];
            end
        end else if (r_state == S_ROUND) begin
            for (int i = 1; i < NUM_HASH_WORDS; i++) begin
                r_wv[i] <= r_wv[i - 1];
            end
            r_wv[4] <= r_wv[3] + w_t1;
            r_wv[0] <= w_t1 + w_t2;
        end
    end

    // Block window: bytes shift in from the right; rounds roll the schedule.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            for (int i = 0; i < NUM_SCHED_WORDS - 1; i++) begin
                r_w[i] <= {r_w[i][23:0], r_w[i + 1][31:24]};
            end
            r_w[NUM_SCHED_WORDS - 1] <= {r_w[NUM_SCHED_WORDS - 1][23:0], w_push_byte};
        end else if (r_state == S_ROUND) begin
            for (int i = 0; i < NUM_SCHED_WORDS - 1; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[NUM_SCHED_WORDS - 1] <= w_new_w;
        end
    end

    // Checks on the sequencer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a digest is being emitted");

    a_round_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) && (r_rnd != LAST_ROUND)
        |=> (r_state == S_ROUND) && (r_rnd == $past(r_rnd) + 6'd1))
        else $error("round sequence broken");

    a_emit_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (o_word_index == 3'd0) && (r_fill == 6'd0))
        else $error("digest emission started mid-block or mid-word");

    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && o_last_word
        |=> o_in_ready && (r_fill == 6'd0) && (r_msg_bytes == 61'd0))
        else $error("hasher did not restart after the final digest word");

    a_len_in_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) && r_last_blk |-> r_fin && r_mark_done)
        else $error("final block compressed without padding");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Feeds messages one byte beat at a time: first a short directed list
// (the empty message, "abc" closed two ways, idle beats and extreme bytes),
// then random messages whose lengths favour the padding boundaries.
// Every digest word is checked against an in-bench SHA-256 model, or
// against a known digest where one is written into the list.
// ----------------------------------------------------------------------------
module testbench;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 300;
    localparam int TARGET_BEATS = 320;
    localparam int QUIET_FROM   = 280;
    localparam int NUM_ROWS     = 18;

    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

    // Message lengths either side of the padding and block boundaries.
    localparam int FILL_EDGES [12] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct {
        bit           has_byte;
        logic [7:0]   data;
        bit           fin;
        bit           known;
        logic [255:0] digest;
    } stim_row_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  pos;
        logic        is_last;
    } digest_beat_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_byte_present = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_end_of_message = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    // Model state of the hasher.
    logic [31:0] sha_hash [8];
    logic [7:0]  sha_block [64];
    int          sha_fill;
    logic [63:0] sha_bit_count;

    digest_beat_t digest_expect [$];
    stim_row_t    stim_rows [NUM_ROWS];
    int           beats_sent = 0;
    int           error_count = 0;
    int           idle_cycles = 0;

    sha256_byte_stream_hasher DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_byte_present   (i_byte_present),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        logic [63:0] twice;
        twice = {v, v} >> n;
        return twice[31:0];
    endfunction

    function automatic void sha_clear();
        for (int j = 0; j < 8; j++) begin
            sha_hash[j] = SHA_IV[j];
        end
        sha_fill      = 0;
        sha_bit_count = '0;
    endfunction

    // One compression of the current block into the hash words.
    function automatic void sha_absorb();
        logic [31:0] win [16];
        logic [31:0] v [8];
        logic [31:0] w, t1, t2, s0, s1, a, e, x15, x2;
        for (int i = 0; i < 16; i++) begin
            win[i] = {sha_block[4*i], sha_block[4*i+1], sha_block[4*i+2], sha_block[4*i+3]};
        end
        for (int j = 0; j < 8; j++) begin
            v[j] = sha_hash[j];
        end
        for (int i = 0; i < 64; i++) begin
            if (i < 16) begin
                w = win[i];
            end else begin
                x15 = win[(i - 15) & 15];
                x2  = win[(i - 2) & 15];
                s0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
                s1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
                w   = win[i & 15] + s0 + win[(i - 7) & 15] + s1;
                win[i & 15] = w;
            end
            a  = v[0];
            e  = v[4];
            t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
               + ((e & v[5]) ^ (~e & v[6])) + SHA_K[i] + w;
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
               + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
            for (int j = 7; j > 0; j--) begin
                v[j] = v[j-1];
            end
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) begin
            sha_hash[j] = sha_hash[j] + v[j];
        end
    endfunction

    // Advances the model by one beat; returns 1 with the digest on a final beat.
    function automatic bit sha_beat(input bit has_byte, input logic [7:0] data,
                                    input bit fin, output logic [255:0] digest);
        digest = '0;
        if (has_byte) begin
            sha_block[sha_fill] = data;
            sha_bit_count       = sha_bit_count + 64'd8;
            sha_fill            = sha_fill + 1;
            if (sha_fill == 64) begin
                sha_absorb();
                sha_fill = 0;
            end
        end
        if (!fin) begin
            return 1'b0;
        end
        sha_block[sha_fill] = 8'h80;
        for (int i = sha_fill + 1; i < 64; i++) begin
            sha_block[i] = 8'h00;
        end
        // No room for the length field: it spills into a second block.
        if (sha_fill >= 56) begin
            sha_absorb();
            for (int i = 0; i < 64; i++) begin
                sha_block[i] = 8'h00;
            end
        end
        for (int i = 0; i < 8; i++) begin
            sha_block[56+i] = sha_bit_count[63-8*i -: 8];
        end
        sha_absorb();
        for (int j = 0; j < 8; j++) begin
            digest[255-32*j -: 32] = sha_hash[j];
        end
        sha_clear();
        return 1'b1;
    endfunction

    // Drives one input beat, waits for it to be taken and records its digest.
    task automatic send_beat(input bit has_byte, input logic [7:0] data, input bit fin,
                             input bit known, input logic [255:0] typed, input bit bursty);
        logic [255:0] predicted;
        logic [255:0] chosen;
        if (bursty && beats_sent < QUIET_FROM && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_byte_present   <= has_byte;
        i_data_byte      <= data;
        i_end_of_message <= fin;
        do @(posedge i_clk); while (!o_in_ready);
        if (sha_beat(has_byte, data, fin, predicted)) begin
            chosen = known ? typed : predicted;
            for (int j = 0; j < 8; j++) begin
                digest_expect.push_back('{chosen[255-32*j -: 32], 3'(j), j == 7});
            end
        end
        if (has_byte || fin) begin
            beats_sent++;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Compare each digest beat taken from the block with the oldest expectation.
    always @(posedge i_clk) begin
        digest_beat_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (digest_expect.size() == 0) begin
                $error("digest beat with no expectation: word %h index %0d",
                       o_digest_word, o_word_index);
                error_count++;
            end else begin
                want = digest_expect.pop_front();
                check_field("digest_word", want.word, o_digest_word);
                check_field("word_index", 32'(want.pos), 32'(o_word_index));
                check_field("last_word", 32'(want.is_last), 32'(o_last_word));
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a beat.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("sha256_byte_stream_hasher regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: ready drops in random bursts until the quiet tail of the run.
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (beats_sent >= QUIET_FROM) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    // Sender: directed list, then random messages.
    initial begin
        int  len;
        bit  end_on_byte;
        bit  bursty;

        // Empty message, an idle beat, then the empty message again.
        stim_rows[0]  = '{1'b0, 8'hff, 1'b1, 1'b1, EMPTY_DIGEST};
        stim_rows[1]  = '{1'b0, 8'h00, 1'b0, 1'b0, '0};
        stim_rows[2]  = '{1'b0, 8'hff, 1'b1, 1'b1, EMPTY_DIGEST};
        // "abc" with the end mark on its last byte.
        stim_rows[3]  = '{1'b1, 8'h61, 1'b0, 1'b0, '0};
        stim_rows[4]  = '{1'b1, 8'h62, 1'b0, 1'b0, '0};
        stim_rows[5]  = '{1'b1, 8'h63, 1'b1, 1'b1, ABC_DIGEST};
        // "abc" closed by an empty final beat after an idle beat.
        stim_rows[6]  = '{1'b1, 8'h61, 1'b0, 1'b0, '0};
        stim_rows[7]  = '{1'b1, 8'h62, 1'b0, 1'b0, '0};
        stim_rows[8]  = '{1'b1, 8'h63, 1'b0, 1'b0, '0};
        stim_rows[9]  = '{1'b0, 8'hff, 1'b0, 1'b0, '0};
        stim_rows[10] = '{1'b0, 8'h00, 1'b1, 1'b1, ABC_DIGEST};
        // Extreme byte values.
        stim_rows[11] = '{1'b1, 8'hff, 1'b0, 1'b0, '0};
        stim_rows[12] = '{1'b1, 8'h00, 1'b1, 1'b0, '0};
        stim_rows[13] = '{1'b1, 8'h00, 1'b1, 1'b0, '0};
        stim_rows[14] = '{1'b1, 8'hff, 1'b1, 1'b0, '0};
        stim_rows[15] = '{1'b0, 8'h5a, 1'b0, 1'b0, '0};
        stim_rows[16] = '{1'b1, 8'ha5, 1'b0, 1'b0, '0};
        stim_rows[17] = '{1'b0, 8'h5a, 1'b1, 1'b0, '0};

        sha_clear();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < NUM_ROWS; r++) begin
            send_beat(stim_rows[r].has_byte, stim_rows[r].data, stim_rows[r].fin,
                      stim_rows[r].known, stim_rows[r].digest, 1'b1);
        end

        // Hold off until the directed digests have all drained.
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (digest_expect.size() != 0);

        while (beats_sent < TARGET_BEATS) begin
            bursty = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 1) == 1) begin
                len = FILL_EDGES[$urandom_range(0, 11)];
            end else begin
                len = $urandom_range(0, 12);
            end
            end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
            for (int k = 0; k < len; k++) begin
                // Occasional idle beat in the middle of a message.
                if ($urandom_range(0, 9) == 0) begin
                    send_beat(1'b0, 8'($urandom), 1'b0, 1'b0, '0, bursty);
                end
                send_beat(1'b1, 8'($urandom), end_on_byte && (k == len - 1), 1'b0, '0,
                          bursty);
            end
            if (!end_on_byte) begin
                send_beat(1'b0, 8'($urandom), 1'b1, 1'b0, '0, bursty);
            end
            if (beats_sent < QUIET_FROM && $urandom_range(0, 3) == 0) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (digest_expect.size() != 0);
            end
        end

        i_in_valid <= 1'b0;
        while (digest_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("sha256_byte_stream_hasher regression: pass");
        end else begin
            $display("sha256_byte_stream_hasher regression: fail");
        end
        $finish;
    end

endmodule
